### hdl/fdis_pkg.sv
// fdis_pkg: shared types, widths and helper functions of the fingerprint
// dissimilarity block. No dependencies.
`default_nettype none

package fdis_pkg;

	localparam int WORD_W      = 16;
	localparam int CNT_W       = 12;
	localparam int WT_W        = 16;
	localparam int RES_W       = 20;
	localparam int POP_W       = 5;
	localparam int PROD_W      = CNT_W + WT_W;
	localparam int DEN_W       = 30;
	localparam int TAN_W       = CNT_W + 2;
	localparam int DIV_W       = 41;
	localparam int DIV_CW      = $clog2(DIV_W);
	localparam int TAN_SHIFT   = 16;
	localparam int TVE_SHIFT   = 28;
	localparam int MAX_WORDS_DEF = 128;
	localparam int JQ_DEPTH    = 2;
	localparam int JQ_AW       = $clog2(JQ_DEPTH);
	localparam int JQ_CW       = $clog2(JQ_DEPTH + 1);
	localparam int APB_DW      = 32;
	localparam int APB_AW      = 4;

	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [RES_W:0]    ONE_Q16  = 21'd65536;
	localparam logic [RES_W-1:0]  RES_MIN  = 20'h80000;
	localparam logic [RES_W-1:0]  RES_MAX  = 20'h7FFFF;
	// largest quotient magnitudes that stay inside the result range
	localparam logic [DIV_W-1:0]  QPOS_LIM = 41'd589824;
	localparam logic [DIV_W-1:0]  QNEG_LIM = 41'd458751;

	localparam logic [WT_W-1:0]   WT_RST   = 16'd4096;

	typedef enum logic [1:0] {
		REG_MEASURE  = 2'd0,
		REG_W_AONLY  = 2'd1,
		REG_W_BONLY  = 2'd2,
		REG_W_COMMON = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_DEN,
		BK_DIV,
		BK_FIN,
		BK_HOLD
	} bk_state_t;

	typedef struct packed {
		logic            measure;
		logic [WT_W-1:0] w_a_only;
		logic [WT_W-1:0] w_b_only;
		logic [WT_W-1:0] w_common;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] common;
		logic [CNT_W-1:0] a_only;
		logic [CNT_W-1:0] b_only;
		logic [CNT_W-1:0] total_a;
		logic [CNT_W-1:0] total_b;
	} job_t;

	function automatic logic [POP_W-1:0] pop16(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] s1;
		logic [WORD_W-1:0] s2;
		logic [WORD_W-1:0] s3;
		logic [WORD_W-1:0] s4;
		s1 = (v & 16'h5555) + ((v >> 1) & 16'h5555);
		s2 = (s1 & 16'h3333) + ((s1 >> 2) & 16'h3333);
		s3 = (s2 & 16'h0F0F) + ((s2 >> 4) & 16'h0F0F);
		s4 = (s3 & 16'h00FF) + ((s3 >> 8) & 16'h00FF);
		return s4[POP_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
			input logic [POP_W-1:0] add);
		logic [CNT_W:0] sum;
		sum = {1'b0, c} + (CNT_W+1)'(add);
		return (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

### hdl/fdis_front.sv
// fdis_front: accepts word pairs, popcounts them and keeps the running counts.
// Hands a finished set of counts to the job queue. Depends on fdis_pkg.
`default_nettype none

module fdis_front #(
	parameter int MAX_WORDS = fdis_pkg::MAX_WORDS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [fdis_pkg::WORD_W-1:0] word_a,
	input  wire logic [fdis_pkg::WORD_W-1:0] word_b,
	input  wire logic                        last_word,
	input  wire logic [fdis_pkg::CNT_W-1:0]  total_bits_a,
	input  wire logic [fdis_pkg::CNT_W-1:0]  total_bits_b,
	input  wire logic                        jq_full,
	output logic                             jq_push,
	output fdis_pkg::job_t                   jq_data
);
	import fdis_pkg::*;

	localparam int WS_W = $clog2(MAX_WORDS + 1);

	logic [CNT_W-1:0] common_q;
	logic [CNT_W-1:0] a_only_q;
	logic [CNT_W-1:0] b_only_q;
	logic [WS_W-1:0]  words_q;
	logic             accept;
	logic             room;
	logic [CNT_W-1:0] common_n;
	logic [CNT_W-1:0] a_only_n;
	logic [CNT_W-1:0] b_only_n;

	assign full   = jq_full;
	assign accept = push && !jq_full;
	assign room   = (words_q < WS_W'(MAX_WORDS));

	// words past the limit are dropped, last_word still closes the comparison
	always_comb begin
		common_n = common_q;
		a_only_n = a_only_q;
		b_only_n = b_only_q;
		if (room) begin
			common_n = sat_add(common_q, pop16(word_a & word_b));
			a_only_n = sat_add(a_only_q, pop16(word_a & ~word_b));
			b_only_n = sat_add(b_only_q, pop16(word_b & ~word_a));
		end
	end

	assign jq_push         = accept && last_word;
	assign jq_data.common  = common_n;
	assign jq_data.a_only  = a_only_n;
	assign jq_data.b_only  = b_only_n;
	assign jq_data.total_a = total_bits_a;
	assign jq_data.total_b = total_bits_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			common_q <= '0;
			a_only_q <= '0;
			b_only_q <= '0;
			words_q  <= '0;
		end else if (accept) begin
			if (last_word) begin
				common_q <= '0;
				a_only_q <= '0;
				b_only_q <= '0;
				words_q  <= '0;
			end else begin
				common_q <= common_n;
				a_only_q <= a_only_n;
				b_only_q <= b_only_n;
				if (room) begin
					words_q <= words_q + WS_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

### hdl/fdis_jobq.sv
// fdis_jobq: short queue of finished count sets between front and back.
// Depends on fdis_pkg.
`default_nettype none

module fdis_jobq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire fdis_pkg::job_t wr_data,
	output logic                full,
	input  wire logic           rd_en,
	output logic                valid,
	output fdis_pkg::job_t      rd_data
);
	import fdis_pkg::*;

	job_t             entry_q [JQ_DEPTH];
	logic [JQ_AW-1:0] wptr_q;
	logic [JQ_AW-1:0] rptr_q;
	logic [JQ_CW-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == JQ_CW'(JQ_DEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_data = entry_q[rptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == JQ_AW'(JQ_DEPTH - 1)) ? '0 : wptr_q + JQ_AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == JQ_AW'(JQ_DEPTH - 1)) ? '0 : rptr_q + JQ_AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + JQ_CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - JQ_CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### hdl/fdis_back.sv
// fdis_back: forms the divisor, runs a bit-serial rounded division and
// clamps the result; holds it until popped. Depends on fdis_pkg.
`default_nettype none

module fdis_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire fdis_pkg::cfg_t              cfg,
	input  wire logic                        job_valid,
	input  wire fdis_pkg::job_t              job,
	output logic                             job_pop,
	input  wire logic                        pop,
	output logic                             empty,
	output logic signed [fdis_pkg::RES_W-1:0] dissimilarity,
	output logic                             undefined,
	output logic                             saturated
);
	import fdis_pkg::*;

	bk_state_t         state_q;
	bk_state_t         state_n;
	job_t              job_q;
	logic [1:0]        step_q;
	logic [DEN_W-1:0]  acc_q;
	logic [DEN_W-1:0]  den_q;
	logic              neg_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [RES_W-1:0]  res_q;
	logic              undef_q;
	logic              sat_q;

	logic [CNT_W-1:0]  mul_a;
	logic [WT_W-1:0]   mul_b;
	logic [PROD_W-1:0] mul_p;
	logic signed [TAN_W-1:0] tan_d;
	logic [TAN_W-1:0]  tan_mag;
	logic [DEN_W-1:0]  den_c;
	logic [DIV_W-1:0]  dvd_c;
	logic [DEN_W:0]    trial;
	logic              take;
	logic [RES_W:0]    diff;

	// one shared multiplier, one weighted count per cycle
	always_comb begin
		case (step_q)
			2'd0: begin
				mul_a = job_q.a_only;
				mul_b = cfg.w_a_only;
			end
			2'd1: begin
				mul_a = job_q.b_only;
				mul_b = cfg.w_b_only;
			end
			default: begin
				mul_a = job_q.common;
				mul_b = cfg.w_common;
			end
		endcase
		mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// divisor and rounding-biased dividend
	always_comb begin
		tan_d   = $signed({2'b00, job_q.total_a}) + $signed({2'b00, job_q.total_b})
			- $signed({2'b00, job_q.common});
		tan_mag = tan_d[TAN_W-1] ? TAN_W'(-tan_d) : TAN_W'(tan_d);
		if (cfg.measure) begin
			den_c = acc_q;
			dvd_c = (DIV_W'(job_q.common) << TVE_SHIFT) + DIV_W'(den_c >> 1);
		end else begin
			den_c = DEN_W'(tan_mag);
			dvd_c = (DIV_W'(job_q.common) << TAN_SHIFT) + DIV_W'(den_c >> 1);
		end
	end

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign take  = (trial >= {1'b0, den_q});
	assign diff  = ONE_Q16 - (RES_W+1)'(quo_q);

	always_comb begin
		state_n = state_q;
		job_pop = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_n = cfg.measure ? BK_MUL : BK_DEN;
				end
			end
			BK_MUL: begin
				if (step_q == 2'd2) begin
					state_n = BK_DEN;
				end
			end
			BK_DEN: begin
				state_n = (den_c == '0) ? BK_HOLD : BK_DIV;
			end
			BK_DIV: begin
				if (cnt_q == DIV_CW'(DIV_W - 1)) begin
					state_n = BK_FIN;
				end
			end
			BK_FIN: begin
				state_n = BK_HOLD;
			end
			BK_HOLD: begin
				if (pop) begin
					state_n = BK_IDLE;
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				job_q  <= job;
				acc_q  <= '0;
				step_q <= '0;
			end
			BK_MUL: begin
				acc_q  <= acc_q + DEN_W'(mul_p);
				step_q <= step_q + 2'd1;
			end
			BK_DEN: begin
				den_q   <= den_c;
				neg_q   <= !cfg.measure && tan_d[TAN_W-1];
				rem_q   <= '0;
				quo_q   <= dvd_c;
				cnt_q   <= '0;
				res_q   <= '0;
				undef_q <= (den_c == '0);
				sat_q   <= 1'b0;
			end
			BK_DIV: begin
				rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
				quo_q <= {quo_q[DIV_W-2:0], take};
				cnt_q <= cnt_q + DIV_CW'(1);
			end
			BK_FIN: begin
				if (neg_q) begin
					// negative divisor: result is one plus the quotient
					if (quo_q > QNEG_LIM) begin
						res_q <= RES_MAX;
						sat_q <= 1'b1;
					end else begin
						res_q <= RES_W'(ONE_Q16 + (RES_W+1)'(quo_q));
					end
				end else begin
					if (quo_q > QPOS_LIM) begin
						res_q <= RES_MIN;
						sat_q <= 1'b1;
					end else begin
						res_q <= diff[RES_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign empty         = (state_q != BK_HOLD);
	assign dissimilarity = $signed(res_q);
	assign undefined     = undef_q;
	assign saturated     = sat_q;

endmodule

`default_nettype wire

### hdl/fingerprint_dissimilarity.sv
// fingerprint_dissimilarity: top level with the configuration registers,
// front counter, job queue and divider back end. Depends on fdis_pkg.
//
// Word pairs enter on push/full, one per cycle; the pair with last_word
// closes a comparison and carries the set-bit totals of A and B. Each
// comparison gives one word on the result side, read with empty/pop:
// dissimilarity (signed, 16 fraction bits), undefined (zero divisor,
// result 0) and saturated (clamped to the 20-bit range).
// The front takes a word every cycle while full is low; counts go into a
// two-entry queue. The back end holds one comparison at a time: it loads
// the counts, in Tversky mode sums the weighted counts on the shared
// multiplier, sets up and runs the 41-bit bit-serial divider and clamps
// the result in a finish step; a zero divisor skips the division. A result
// stays on the ports until popped; the back end waits meanwhile while the
// front keeps counting until the queue fills, then full rises.
// Configuration is written on the APB port while the block is idle: the
// user is bound to this, the block itself does not enforce it.
// Reset clears counts and queue, empties the result side and loads the
// default weights.
`default_nettype none

module fingerprint_dissimilarity #(
	parameter int MAX_WORDS = fdis_pkg::MAX_WORDS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fdis_pkg::APB_AW-1:0] paddr,
	input  wire logic [fdis_pkg::APB_DW-1:0] pwdata,
	output logic      [fdis_pkg::APB_DW-1:0] prdata,
	output logic                             pready,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [fdis_pkg::WORD_W-1:0] word_a,
	input  wire logic [fdis_pkg::WORD_W-1:0] word_b,
	input  wire logic                        last_word,
	input  wire logic [fdis_pkg::CNT_W-1:0]  total_bits_a,
	input  wire logic [fdis_pkg::CNT_W-1:0]  total_bits_b,
	output logic                             empty,
	input  wire logic                        pop,
	output logic signed [fdis_pkg::RES_W-1:0] dissimilarity,
	output logic                             undefined,
	output logic                             saturated
);
	import fdis_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;
	logic     jq_full;
	logic     jq_push;
	job_t     jq_wdata;
	logic     jq_valid;
	logic     jq_pop;
	job_t     jq_rdata;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.measure  <= 1'b0;
			cfg_q.w_a_only <= WT_RST;
			cfg_q.w_b_only <= WT_RST;
			cfg_q.w_common <= WT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MEASURE:  cfg_q.measure  <= pwdata[0];
				REG_W_AONLY:  cfg_q.w_a_only <= pwdata[WT_W-1:0];
				REG_W_BONLY:  cfg_q.w_b_only <= pwdata[WT_W-1:0];
				REG_W_COMMON: cfg_q.w_common <= pwdata[WT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MEASURE:  prdata = APB_DW'(cfg_q.measure);
			REG_W_AONLY:  prdata = APB_DW'(cfg_q.w_a_only);
			REG_W_BONLY:  prdata = APB_DW'(cfg_q.w_b_only);
			REG_W_COMMON: prdata = APB_DW'(cfg_q.w_common);
			default:      prdata = '0;
		endcase
	end

	fdis_front #(
		.MAX_WORDS(MAX_WORDS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.word_a       (word_a),
		.word_b       (word_b),
		.last_word    (last_word),
		.total_bits_a (total_bits_a),
		.total_bits_b (total_bits_b),
		.jq_full      (jq_full),
		.jq_push      (jq_push),
		.jq_data      (jq_wdata)
	);

	fdis_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (jq_push),
		.wr_data (jq_wdata),
		.full    (jq_full),
		.rd_en   (jq_pop),
		.valid   (jq_valid),
		.rd_data (jq_rdata)
	);

	fdis_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.job_valid     (jq_valid),
		.job           (jq_rdata),
		.job_pop       (jq_pop),
		.pop           (pop),
		.empty         (empty),
		.dissimilarity (dissimilarity),
		.undefined     (undefined),
		.saturated     (saturated)
	);

endmodule

`default_nettype wire

### hdl/fdis_check.sv
// fdis_check: port-level checks of the fingerprint dissimilarity block,
// bound to the top level. Depends on fdis_pkg.
`default_nettype none

module fdis_check (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        empty,
	input wire logic                        pop,
	input wire logic signed [fdis_pkg::RES_W-1:0] dissimilarity,
	input wire logic                        undefined,
	input wire logic                        saturated
);
	import fdis_pkg::*;

	// a zero divisor gives a plain zero word
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && undefined) |-> (dissimilarity == '0 && !saturated))
		else $error("undefined word with nonzero payload");

	// clamped words sit at one end of the range
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && saturated) |->
		($unsigned(dissimilarity) == RES_MIN || $unsigned(dissimilarity) == RES_MAX))
		else $error("saturated word off the rails");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result word dropped before pop");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(dissimilarity) && $stable(undefined)
		&& $stable(saturated)))
		else $error("result word changed while waiting");

endmodule

bind fingerprint_dissimilarity fdis_check u_fdis_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.dissimilarity (dissimilarity),
	.undefined     (undefined),
	.saturated     (saturated)
);

`default_nettype wire

### tb/tb_fingerprint_dissimilarity.sv
`timescale 1ns / 1ps
// tb_fingerprint_dissimilarity: self-checking testbench of the fingerprint dissimilarity block,
// with a clocked driver and monitor and a scoring model of its own. Depends on fdis_pkg.

module tb_fingerprint_dissimilarity;
	import fdis_pkg::*;

	localparam int     WORDS_CAP   = 128;
	localparam int     COUNT_CAP   = 4095;
	localparam longint Q16_ONE     = 65536;
	localparam longint LO_CLAMP    = -524288;
	localparam longint HI_CLAMP    = 524287;
	localparam int     SETTLE      = 60;
	localparam int     PHASE_ITEMS = 250;
	localparam int     HOLD_CYCLES = 600;
	localparam int     STOP_CYCLE  = 400000;

	typedef struct {
		logic [WORD_W-1:0] word_a;
		logic [WORD_W-1:0] word_b;
		logic              last;
		logic [CNT_W-1:0]  total_a;
		logic [CNT_W-1:0]  total_b;
	} pair_t;

	typedef struct {
		logic signed [RES_W-1:0] dis;
		logic                    undef;
		logic                    sat;
	} score_t;

	logic                    clk;
	logic                    arst_n  = 1'b0;
	logic                    psel    = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite  = 1'b0;
	logic [APB_AW-1:0]       paddr   = '0;
	logic [APB_DW-1:0]       pwdata  = '0;
	logic [APB_DW-1:0]       prdata;
	logic                    pready;
	logic                    push    = 1'b0;
	logic                    full;
	logic [WORD_W-1:0]       word_a  = '0;
	logic [WORD_W-1:0]       word_b  = '0;
	logic                    last_word = 1'b0;
	logic [CNT_W-1:0]        total_bits_a = '0;
	logic [CNT_W-1:0]        total_bits_b = '0;
	logic                    empty;
	logic                    pop     = 1'b0;
	logic signed [RES_W-1:0] dissimilarity;
	logic                    undefined;
	logic                    saturated;

	pair_t  pairs_q[$];
	score_t scores_q[$];
	pair_t  cur_pair;
	cfg_t   cfg_model = '{1'b0, WT_RST, WT_RST, WT_RST};
	int     acc_common = 0;
	int     acc_a_only = 0;
	int     acc_b_only = 0;
	int     acc_words  = 0;
	int     offered    = 0;
	int     bad_cnt    = 0;
	int     burst_left = 0;
	int     gap_left   = 0;
	int     hold_left  = 0;
	bit     hold_req   = 1'b0;
	bit     hold_done  = 1'b0;
	logic [15:0] rx_tick = '0;
	int     cycle_cnt  = 0;

	fingerprint_dissimilarity #(.MAX_WORDS(WORDS_CAP)) u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full),
		.word_a(word_a), .word_b(word_b), .last_word(last_word),
		.total_bits_a(total_bits_a), .total_bits_b(total_bits_b),
		.empty(empty), .pop(pop),
		.dissimilarity(dissimilarity), .undefined(undefined), .saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int clip_count(input int v);
		return (v > COUNT_CAP) ? COUNT_CAP : v;
	endfunction

	// adds one accepted word to the running counts up to the word cap, scores the comparison on last_word
	task automatic fold_word(input pair_t p);
		score_t s;
		longint d;
		longint q;
		longint res;
		longint unsigned num;
		longint unsigned den;
		if (acc_words < WORDS_CAP) begin
			acc_common = clip_count(acc_common + $countones(p.word_a & p.word_b));
			acc_a_only = clip_count(acc_a_only + $countones(p.word_a & ~p.word_b));
			acc_b_only = clip_count(acc_b_only + $countones(p.word_b & ~p.word_a));
			acc_words++;
		end
		if (p.last) begin
			s.undef = 1'b0;
			s.sat = 1'b0;
			res = 0;
			if (!cfg_model.measure) begin
				d = longint'(p.total_a) + longint'(p.total_b) - longint'(acc_common);
				if (d == 0) begin
					s.undef = 1'b1;
				end else begin
					den = (d < 0) ? -d : d;
					num = longint'(acc_common) << TAN_SHIFT;
					q = (num + den / 2) / den;
					res = Q16_ONE - ((d < 0) ? -q : q);
				end
			end else begin
				den = longint'(acc_a_only) * cfg_model.w_a_only
					+ longint'(acc_b_only) * cfg_model.w_b_only
					+ longint'(acc_common) * cfg_model.w_common;
				if (den == 0) begin
					s.undef = 1'b1;
				end else begin
					num = longint'(acc_common) << TVE_SHIFT;
					q = (num + den / 2) / den;
					res = Q16_ONE - q;
				end
			end
			if (res < LO_CLAMP) begin
				res = LO_CLAMP;
				s.sat = 1'b1;
			end else if (res > HI_CLAMP) begin
				res = HI_CLAMP;
				s.sat = 1'b1;
			end
			s.dis = res[RES_W-1:0];
			scores_q.push_back(s);
			acc_common = 0;
			acc_a_only = 0;
			acc_b_only = 0;
			acc_words = 0;
		end
	endtask

	task automatic flag_mismatch(input string what, input longint want, input longint got);
		if (bad_cnt < 40)
			$display("%0t ns %s: want %0d got %0d", $time, what, want, got);
		bad_cnt++;
	endtask

	// driver: bursts of words with random gaps, word held until taken
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				fold_word(cur_pair);
			if (push && full) begin
				// hold the offered word
			end else if (gap_left != 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (pairs_q.size() != 0) begin
				cur_pair = pairs_q.pop_front();
				push <= 1'b1;
				word_a <= cur_pair.word_a;
				word_b <= cur_pair.word_b;
				last_word <= cur_pair.last;
				total_bits_a <= cur_pair.total_a;
				total_bits_b <= cur_pair.total_b;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor: checks each popped word, stalls on a pattern keyed to its own tick count and once on hold_req
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			score_t want;
			rx_tick <= rx_tick + 16'd1;
			if (pop && !empty) begin
				if (scores_q.size() == 0) begin
					flag_mismatch("result with no comparison open", 0, longint'(dissimilarity));
				end else begin
					want = scores_q.pop_front();
					if (dissimilarity !== want.dis)
						flag_mismatch("dissimilarity", longint'(want.dis), longint'(dissimilarity));
					if (undefined !== want.undef)
						flag_mismatch("undefined", want.undef, undefined);
					if (saturated !== want.sat)
						flag_mismatch("saturated", want.sat, saturated);
				end
			end
			if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				pop <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				pop <= 1'b0;
			end else begin
				case (rx_tick[9:8])
					2'd0: pop <= 1'b1;
					2'd1: pop <= 1'($urandom_range(0, 1));
					2'd2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == STOP_CYCLE) begin
			$display("fingerprint_dissimilarity: mismatch");
			$finish;
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(4 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MEASURE:  cfg_model.measure  = val[0];
			REG_W_AONLY:  cfg_model.w_a_only = val[WT_W-1:0];
			REG_W_BONLY:  cfg_model.w_b_only = val[WT_W-1:0];
			REG_W_COMMON: cfg_model.w_common = val[WT_W-1:0];
		endcase
	endtask

	task automatic offer(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
			input logic last, input logic [CNT_W-1:0] ta, input logic [CNT_W-1:0] tb);
		pair_t p;
		p.word_a = a;
		p.word_b = b;
		p.last = last;
		p.total_a = ta;
		p.total_b = tb;
		pairs_q.push_back(p);
		offered++;
	endtask

	// waits until every word is taken and every result popped, then lets the back end settle
	task automatic drain();
		@(negedge clk);
		while (pairs_q.size() != 0 || push || scores_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h0001 << $urandom_range(0, 15);
			3: return ~(16'h0001 << $urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [WT_W-1:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return WT_RST;
			3: return 16'($urandom_range(1, 16));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 6);
		if (r < 98) return $urandom_range(7, 32);
		return $urandom_range(WORDS_CAP - 8, WORDS_CAP + 12);
	endfunction

	// one well-formed comparison; totals mostly match the words, sometimes not
	task automatic offer_comparison(input int len);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		int pa;
		int pb;
		int k;
		int mode;
		pa = 0;
		pb = 0;
		mode = $urandom_range(0, 99);
		for (k = 0; k < len; k++) begin
			a = rand_word();
			b = ($urandom_range(0, 2) == 0) ? (a ^ (16'h0001 << $urandom_range(0, 15))) :
				rand_word();
			pa += $countones(a);
			pb += $countones(b);
			if (k != len - 1)
				offer(a, b, 1'b0, 12'($urandom), 12'($urandom));
			else if (mode < 70)
				offer(a, b, 1'b1, 12'(pa), 12'(pb));
			else if (mode < 85)
				offer(a, b, 1'b1, 12'($urandom), 12'($urandom));
			else
				offer(a, b, 1'b1, 12'(pa + $urandom_range(0, 6) - 3),
					12'(pb + $urandom_range(0, 6) - 3));
		end
	endtask

	task automatic random_phase(input bit tversky, input bit squeeze);
		int start;
		reg_write(REG_MEASURE, 32'(tversky));
		reg_write(REG_W_AONLY, 32'(pick_weight()));
		reg_write(REG_W_BONLY, 32'(pick_weight()));
		reg_write(REG_W_COMMON, 32'(pick_weight()));
		@(negedge clk);
		// receiver goes quiet while the sender keeps pushing, so full has to rise
		if (squeeze)
			hold_req = 1'b1;
		start = offered;
		while (offered - start < PHASE_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				offer(rand_word(), rand_word(), 1'($urandom_range(0, 1)),
					12'($urandom), 12'($urandom));
			offer_comparison(pick_len());
		end
		drain();
	endtask

	initial begin
		int p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// tanimoto at reset defaults: zero divisor, exact match, disjoint, bad totals, clamps
		@(negedge clk);
		offer(16'h0000, 16'h0000, 1'b1, 12'd0, 12'd0);
		offer(16'hFFFF, 16'hFFFF, 1'b1, 12'd16, 12'd16);
		offer(16'hFFFF, 16'h0000, 1'b1, 12'd16, 12'd0);
		offer(16'h0000, 16'hFFFF, 1'b1, 12'd0, 12'd16);
		offer(16'hFFFF, 16'hFFFF, 1'b1, 12'd0, 12'd0);
		offer(16'hFFFF, 16'hFFFF, 1'b1, 12'd0, 12'd15);
		offer(16'hFFFF, 16'hFFFF, 1'b1, 12'd16, 12'd1);
		offer(16'hAAAA, 16'h5555, 1'b0, 12'hFFF, 12'hFFF);
		offer(16'h5555, 16'h5555, 1'b1, 12'hFFF, 12'hFFF);
		drain();

		// tversky with default, zero, full-scale and tiny weights
		reg_write(REG_MEASURE, 32'd1);
		@(negedge clk);
		offer(16'hF0F0, 16'hFF00, 1'b1, 12'd0, 12'd0);
		offer(16'h0000, 16'h0000, 1'b1, 12'd0, 12'd0);
		drain();
		reg_write(REG_W_AONLY, 32'd0);
		reg_write(REG_W_BONLY, 32'd0);
		reg_write(REG_W_COMMON, 32'd0);
		@(negedge clk);
		offer(16'hFFFF, 16'h1234, 1'b1, 12'd0, 12'd0);
		drain();
		reg_write(REG_W_AONLY, 32'hFFFF);
		reg_write(REG_W_BONLY, 32'hFFFF);
		reg_write(REG_W_COMMON, 32'hFFFF);
		@(negedge clk);
		offer(16'hFFFF, 16'hFFFF, 1'b1, 12'd0, 12'd0);
		offer(16'h1234, 16'hFEDC, 1'b1, 12'd0, 12'd0);
		drain();
		reg_write(REG_W_AONLY, 32'd0);
		reg_write(REG_W_BONLY, 32'd0);
		reg_write(REG_W_COMMON, 32'd1);
		@(negedge clk);
		offer(16'hFFFF, 16'hFFFF, 1'b1, 12'd0, 12'd0);
		offer(16'h00FF, 16'h0FFF, 1'b1, 12'd0, 12'd0);
		drain();

		for (p = 0; p < 7; p++)
			random_phase(p % 2 == 1, p == 2);

		if (bad_cnt == 0)
			$display("fingerprint_dissimilarity: match");
		else
			$display("fingerprint_dissimilarity: mismatch");
		$finish;
	end

endmodule
